// ===== sv/mmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// mmpd_pkg: shared types and constants
// Result and bundle types, marker characters and the hex digit lookup.
// ----------------------------------------------------------------------------
package mmpd_pkg;

  localparam int unsigned MAX_RES    = 3;
  localparam int unsigned QDEPTH_DEF = 4;
  localparam logic [2:0]  START_LEN  = 3'd6;

  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [3:0] HEX_TEN    = 4'ha;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_end;
    logic       found;
  } result_t;

  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic    [1:0]         cnt;
  } bundle_t;

  function automatic logic [7:0] start_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = CH_SLASH;
      3'd1:    c = CH_AMP;
      3'd2:    c = 8'h4d;
      3'd3:    c = 8'h53;
      3'd4:    c = 8'h47;
      3'd5:    c = 8'h3d;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = HEX_TEN + (c[3:0] - 4'd1);
    end
    return v;
  endfunction

endpackage

// ===== sv/marked_message_percent_decoder.sv =====
// ----------------------------------------------------------------------------
// marked_message_percent_decoder: top level
// Accepted bundles enter the bundle queue, then the single output register.
// Throughput: one item per cycle while each yields at most one result and the
// output does not stall; an item with k results takes k output-register loads.
// The bundle queue (QDEPTH entries) decouples input from output stalls.
// Reset (rst_n low, synchronous) rearms the marker search and empties all.
// ----------------------------------------------------------------------------
module marked_message_percent_decoder
  import mmpd_pkg::*;
#(
  parameter int unsigned QDEPTH = QDEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_stream_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_end,
  output logic       out_found,
  output logic       out_last_of_item
);

  bundle_t front_bundle;
  bundle_t q_head;
  logic    accept;
  logic    q_push;
  logic    q_pop;
  logic    q_not_empty;
  logic    q_full;
  logic [$clog2(QDEPTH+1)-1:0] q_count;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (front_bundle.cnt != 2'd0);

  mmpd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_byte      (in_byte),
    .in_stream_end(in_stream_end),
    .bundle       (front_bundle)
  );

  mmpd_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(front_bundle),
    .pop      (q_pop),
    .head     (q_head),
    .not_empty(q_not_empty),
    .full     (q_full),
    .count    (q_count)
  );

  mmpd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .head_valid      (q_not_empty),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_is_end      (out_is_end),
    .out_found       (out_found),
    .out_last_of_item(out_last_of_item)
  );

  a_found_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_is_end)
    else $error("found set on a byte result");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_end |-> out_last_of_item && (out_byte == 8'd0))
    else $error("end report not last or carries data");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= ($clog2(QDEPTH+1))'(QDEPTH))
    else $error("queue count out of range");

  a_bundle_count: assert property (@(posedge clk) disable iff (!rst_n)
    q_not_empty |-> (q_head.cnt != 2'd0))
    else $error("empty bundle queued");

endmodule

// ===== sv/mmpd_front.sv =====
// ----------------------------------------------------------------------------
// mmpd_front: marker search and escape classification
// Updates parse state per accepted byte and forms a bundle of up to three
// results for the queue.
// ----------------------------------------------------------------------------
module mmpd_front
  import mmpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_stream_end,
  output bundle_t    bundle
);

  typedef enum logic [1:0] {PH_SEARCH, PH_BODY, PH_DONE} phase_t;
  typedef enum logic [1:0] {PK_NONE, PK_PERCENT, PK_ESCAPE} pend_t;

  phase_t     phase_r, phase_nxt;
  pend_t      pend_r, pend_nxt;
  logic [2:0] mpos_r, mpos_nxt;
  logic [3:0] hnib_r, hnib_nxt;

  always_comb begin
    logic [2:0] pos;
    logic [1:0] n;
    logic       do_fresh;
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    mpos_nxt  = mpos_r;
    hnib_nxt  = hnib_r;
    n         = 2'd0;
    do_fresh  = 1'b0;
    pos       = 3'd0;
    bundle    = '0;
    case (phase_r)
      PH_SEARCH: begin
        pos = (mpos_r >= START_LEN) ? 3'd0 : mpos_r;
        if (in_byte == start_char(pos)) begin
          pos = pos + 3'd1;
        end else begin
          pos = (in_byte == CH_SLASH) ? 3'd1 : 3'd0;
        end
        if (pos == START_LEN) begin
          phase_nxt = PH_BODY;
          mpos_nxt  = 3'd0;
          pend_nxt  = PK_NONE;
          hnib_nxt  = 4'd0;
        end else begin
          mpos_nxt = pos;
        end
      end
      PH_BODY: begin
        if (mpos_r != 3'd0) begin
          if (in_byte == CH_AMP) begin
            bundle.res[n] = '{byte_val: 8'd0, is_end: 1'b1, found: 1'b1};
            n         = n + 2'd1;
            phase_nxt = PH_DONE;
            mpos_nxt  = 3'd0;
            pend_nxt  = PK_NONE;
            hnib_nxt  = 4'd0;
          end else begin
            bundle.res[n] = '{byte_val: (pend_r == PK_ESCAPE) ? {hnib_r, 4'd0} : CH_SLASH,
                              is_end: 1'b0, found: 1'b0};
            n        = n + 2'd1;
            mpos_nxt = 3'd0;
            pend_nxt = PK_NONE;
            do_fresh = 1'b1;
          end
        end else if (pend_r == PK_PERCENT) begin
          if (is_digit(in_byte)) begin
            pend_nxt = PK_ESCAPE;
            hnib_nxt = in_byte[3:0];
          end else begin
            bundle.res[n] = '{byte_val: CH_PERCENT, is_end: 1'b0, found: 1'b0};
            n        = n + 2'd1;
            pend_nxt = PK_NONE;
            do_fresh = 1'b1;
          end
        end else if (pend_r == PK_ESCAPE) begin
          if (in_byte == CH_SLASH) begin
            mpos_nxt = 3'd1;
          end else begin
            bundle.res[n] = '{byte_val: {hnib_r, hex_value(in_byte)},
                              is_end: 1'b0, found: 1'b0};
            n        = n + 2'd1;
            pend_nxt = PK_NONE;
          end
        end else begin
          pend_nxt = PK_NONE;
          do_fresh = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (do_fresh) begin
      if (in_byte == CH_SLASH) begin
        mpos_nxt = 3'd1;
      end else if (in_byte == CH_PERCENT) begin
        pend_nxt = PK_PERCENT;
      end else begin
        bundle.res[n] = '{byte_val: in_byte, is_end: 1'b0, found: 1'b0};
        n = n + 2'd1;
      end
    end
    if (in_stream_end) begin
      if (phase_nxt == PH_SEARCH || phase_nxt == PH_BODY) begin
        bundle.res[n] = '{byte_val: 8'd0, is_end: 1'b1, found: 1'b0};
        n = n + 2'd1;
      end
      phase_nxt = PH_SEARCH;
      mpos_nxt  = 3'd0;
      pend_nxt  = PK_NONE;
      hnib_nxt  = 4'd0;
    end
    bundle.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      pend_r  <= PK_NONE;
      mpos_r  <= 3'd0;
      hnib_r  <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      mpos_r  <= mpos_nxt;
      hnib_r  <= hnib_nxt;
    end
  end

endmodule

// ===== sv/mmpd_queue.sv =====
// ----------------------------------------------------------------------------
// mmpd_queue: bundle queue
// Short register queue between the front and back halves.
// ----------------------------------------------------------------------------
module mmpd_queue
  import mmpd_pkg::*;
#(
  parameter int unsigned DEPTH = QDEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output logic    not_empty,
  output logic    full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  bundle_t          mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt;
  logic [PW-1:0]    rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign head      = mem_r[rd_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CW'(DEPTH));
  assign count     = cnt_r;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

// ===== sv/mmpd_back.sv =====
// ----------------------------------------------------------------------------
// mmpd_back: result serializer
// Loads head results into the output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module mmpd_back
  import mmpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  bundle_t    head,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_end,
  output logic       out_found,
  output logic       out_last_of_item
);

  logic       valid_r;
  logic [1:0] idx_r, idx_nxt;
  result_t    res_r;
  logic       last_r;
  logic       load;
  logic       at_last;

  assign load    = head_valid && (!valid_r || out_ready);
  assign at_last = (idx_r == head.cnt - 2'd1);
  assign pop     = load && at_last;
  assign idx_nxt = at_last ? 2'd0 : idx_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= idx_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
    if (load) begin
      res_r  <= head.res[idx_r];
      last_r <= at_last;
    end
  end

  assign out_valid        = valid_r;
  assign out_byte         = res_r.byte_val;
  assign out_is_end       = res_r.is_end;
  assign out_found        = res_r.found;
  assign out_last_of_item = last_r;

endmodule
